[design/lctd_pkg.sv]
// Shared types, constants and the microprogram for the legacy charset text decoder.
// Used by lctd_useq, lctd_dpath and legacy_charset_text_decoder.
package lctd_pkg;

  localparam int unsigned MaxIndent = 44;
  localparam int unsigned CntW      = 6;
  localparam int unsigned UaddrW    = 4;

  typedef logic [UaddrW-1:0] uaddr_t;
  typedef logic [CntW-1:0]   cnt_t;

  // Configuration register indexes.
  localparam logic CFG_ASCII_MODE   = 1'b0;
  localparam logic CFG_INDENT_WIDTH = 1'b1;

  // Microprogram addresses.
  localparam uaddr_t UA_TERM    = 4'd0;
  localparam uaddr_t UA_PASS    = 4'd1;
  localparam uaddr_t UA_HEX     = 4'd2;
  localparam uaddr_t UA_OPEN    = 4'd6;
  localparam uaddr_t UA_CHR     = 4'd7;
  localparam uaddr_t UA_CLOSE   = 4'd8;
  localparam uaddr_t UA_NL      = 4'd10;
  localparam uaddr_t UA_SPACE   = 4'd11;
  localparam uaddr_t UA_SEMI    = 4'd12;

  // Character codes.
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOWA   = 8'h61;
  localparam logic [7:0] ASCII_TERM  = 8'h00;
  localparam logic [7:0] LEGACY_TERM = 8'h01;
  localparam logic [7:0] ASCII_LO    = 8'h20;
  localparam logic [7:0] ASCII_HI    = 8'h7A;
  localparam logic [6:0] LEGACY_NL   = 7'h76;

  typedef enum logic [1:0] {SRC_CHR, SRC_LIT, SRC_HEXHI, SRC_HEXLO} src_e;
  typedef enum logic [1:0] {LAST_NO, LAST_YES, LAST_CNTZ, LAST_SPC} last_e;
  typedef enum logic [1:0] {INV_KEEP, INV_SET, INV_CLR} inv_e;
  // SEQ_NL: jump to target when the item is a newline, else fall through.
  // SEQ_SKIPZ: finish when no spaces are due, else fall through.
  // SEQ_LOOP: repeat target while more spaces remain, then fall through to
  // the semicolon or finish.
  typedef enum logic [2:0] {SEQ_NEXT, SEQ_DONE, SEQ_NL, SEQ_SKIPZ, SEQ_LOOP} seq_e;

  typedef struct packed {
    logic       emit;
    src_e       src;
    logic [7:0] lit;
    last_e      last;
    inv_e       inv;
    logic       dec;
    seq_e       seq;
    uaddr_t     tgt;
  } ucode_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic nl;
    logic cnt_z;
    logic cnt_one;
    logic semi;
  } stat_t;

  // Control from the sequencer to the datapath; its strobes are already qualified by the step.
  typedef struct packed {
    logic       emit;
    src_e       src;
    logic [7:0] lit;
    logic       last;
    logic       inv_set;
    logic       inv_clr;
    logic       dec;
  } ctrl_t;

  function automatic ucode_t uw(input logic emit, input src_e src, input logic [7:0] lit,
                                input last_e last, input inv_e inv, input logic dec,
                                input seq_e seq, input uaddr_t tgt);
    ucode_t w;
    w.emit = emit;
    w.src  = src;
    w.lit  = lit;
    w.last = last;
    w.inv  = inv;
    w.dec  = dec;
    w.seq  = seq;
    w.tgt  = tgt;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input uaddr_t a);
    ucode_t w;
    case (a)
      UA_TERM:  w = uw(1'b0, SRC_LIT, 8'h00, LAST_NO, INV_CLR, 1'b0, SEQ_DONE, UA_TERM);
      UA_PASS:  w = uw(1'b1, SRC_CHR, 8'h00, LAST_YES, INV_KEEP, 1'b0, SEQ_DONE, UA_TERM);
      UA_HEX:   w = uw(1'b1, SRC_LIT, CH_LBRACE, LAST_NO, INV_KEEP, 1'b0, SEQ_NEXT, UA_TERM);
      4'd3:     w = uw(1'b1, SRC_HEXHI, 8'h00, LAST_NO, INV_KEEP, 1'b0, SEQ_NEXT, UA_TERM);
      4'd4:     w = uw(1'b1, SRC_HEXLO, 8'h00, LAST_NO, INV_KEEP, 1'b0, SEQ_NEXT, UA_TERM);
      4'd5:     w = uw(1'b1, SRC_LIT, CH_RBRACE, LAST_YES, INV_KEEP, 1'b0, SEQ_DONE, UA_TERM);
      UA_OPEN:  w = uw(1'b1, SRC_LIT, CH_LBRACK, LAST_NO, INV_SET, 1'b0, SEQ_NL, UA_NL);
      UA_CHR:   w = uw(1'b1, SRC_CHR, 8'h00, LAST_YES, INV_KEEP, 1'b0, SEQ_DONE, UA_TERM);
      UA_CLOSE: w = uw(1'b1, SRC_LIT, CH_RBRACK, LAST_NO, INV_CLR, 1'b0, SEQ_NL, UA_NL);
      4'd9:     w = uw(1'b1, SRC_CHR, 8'h00, LAST_YES, INV_KEEP, 1'b0, SEQ_DONE, UA_TERM);
      UA_NL:    w = uw(1'b1, SRC_LIT, CH_LF, LAST_CNTZ, INV_KEEP, 1'b0, SEQ_SKIPZ, UA_TERM);
      UA_SPACE: w = uw(1'b1, SRC_LIT, CH_SPACE, LAST_SPC, INV_KEEP, 1'b1, SEQ_LOOP, UA_SPACE);
      UA_SEMI:  w = uw(1'b1, SRC_LIT, CH_SEMI, LAST_YES, INV_KEEP, 1'b0, SEQ_DONE, UA_TERM);
      default:  w = uw(1'b0, SRC_LIT, 8'h00, LAST_NO, INV_KEEP, 1'b0, SEQ_DONE, UA_TERM);
    endcase
    return w;
  endfunction

  function automatic logic [7:0] sym_lookup(input logic [5:0] c);
    logic [7:0] s;
    case (c)
      6'd0:  s = 8'h20;
      6'd11: s = 8'h22;
      6'd12: s = 8'hA3;
      6'd13: s = 8'h24;
      6'd14: s = 8'h3A;
      6'd15: s = 8'h3F;
      6'd16: s = 8'h28;
      6'd17: s = 8'h29;
      6'd18: s = 8'h3E;
      6'd19: s = 8'h3C;
      6'd20: s = 8'h3D;
      6'd21: s = 8'h2B;
      6'd22: s = 8'h2D;
      6'd23: s = 8'h2A;
      6'd24: s = 8'h2F;
      6'd25: s = 8'h3B;
      6'd26: s = 8'h2C;
      6'd27: s = 8'h2E;
      default: begin
        if (c <= 6'd10) begin
          s = 8'h60 + {2'b00, c};         // a..j
        end else if (c <= 6'd37) begin
          s = 8'h30 + {2'b00, c - 6'd28}; // 0..9
        end else begin
          s = 8'h41 + {2'b00, c - 6'd38}; // A..Z
        end
      end
    endcase
    return s;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] d;
    if (v < 4'd10) begin
      d = CH_ZERO + {4'h0, v};
    end else begin
      d = CH_LOWA + {4'h0, v - 4'd10};
    end
    return d;
  endfunction

endpackage

[design/lctd_useq.sv]
// Microcode sequencer: step counter, control ROM from lctd_pkg and jump logic.
// Drives lctd_dpath through a ctrl_t word; depends on lctd_pkg.
module lctd_useq import lctd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  uaddr_t entry_i,
  input  stat_t  stat_i,
  input  logic   out_free_i,
  output ctrl_t  ctrl_o,
  output logic   busy_o
);

  logic   busy_q, busy_d;
  uaddr_t upc_q, upc_d;
  ucode_t cw;
  logic   step;
  logic   last;

  assign cw   = ucode_rom(upc_q);
  // A step that emits waits for room in the output register.
  assign step = busy_q && (!cw.emit || out_free_i);

  always_comb begin
    case (cw.last)
      LAST_NO:   last = 1'b0;
      LAST_YES:  last = 1'b1;
      LAST_CNTZ: last = stat_i.cnt_z;
      LAST_SPC:  last = stat_i.cnt_one && !stat_i.semi;
      default:   last = 1'b0;
    endcase
  end

  always_comb begin
    ctrl_o.emit    = step && cw.emit;
    ctrl_o.src     = cw.src;
    ctrl_o.lit     = cw.lit;
    ctrl_o.last    = last;
    ctrl_o.inv_set = step && (cw.inv == INV_SET);
    ctrl_o.inv_clr = step && (cw.inv == INV_CLR);
    ctrl_o.dec     = step && cw.dec;
  end

  always_comb begin
    upc_d  = upc_q;
    busy_d = busy_q;
    if (start_i) begin
      upc_d  = entry_i;
      busy_d = 1'b1;
    end else if (step) begin
      case (cw.seq)
        SEQ_NEXT: upc_d = upc_q + 1'b1;
        SEQ_DONE: busy_d = 1'b0;
        SEQ_NL: begin
          upc_d = stat_i.nl ? cw.tgt : upc_q + 1'b1;
        end
        SEQ_SKIPZ: begin
          if (stat_i.cnt_z) begin
            busy_d = 1'b0;
          end else begin
            upc_d = upc_q + 1'b1;
          end
        end
        SEQ_LOOP: begin
          if (!stat_i.cnt_z && !stat_i.cnt_one) begin
            upc_d = cw.tgt;
          end else if (stat_i.semi) begin
            upc_d = upc_q + 1'b1;
          end else begin
            busy_d = 1'b0;
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      upc_q  <= UA_TERM;
    end else begin
      busy_q <= busy_d;
      upc_q  <= upc_d;
    end
  end

  assign busy_o = busy_q;

endmodule

[design/lctd_dpath.sv]
// Datapath: byte decode and dispatch, space counter, inverse flag and output register.
// Controlled by lctd_useq through ctrl_t; depends on lctd_pkg.
module lctd_dpath import lctd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] code_i,
  input  logic       ascii_mode_i,
  input  cnt_t       indent_i,
  input  ctrl_t      ctrl_i,
  input  logic       out_ready_i,
  output uaddr_t     entry_o,
  output stat_t      stat_o,
  output logic       out_free_o,
  output logic       out_valid_o,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);

  logic       inv_q, inv_d;
  logic [7:0] byte_q;
  logic [7:0] chr_q, chr_d;
  logic       nl_q, nl_d;
  cnt_t       cnt_q, cnt_d;
  logic       semi_q;
  logic       ovalid_q, ovalid_d;
  logic [7:0] ochar_q;
  logic       olast_q;
  logic [7:0] emit_char;
  cnt_t       cnt_sat;
  logic [6:0] low7;

  assign low7    = code_i[6:0];
  assign cnt_sat = (indent_i > cnt_t'(MaxIndent)) ? cnt_t'(MaxIndent) : indent_i;

  // Dispatch: pick the microprogram entry and the character for this byte.
  always_comb begin
    entry_o = UA_TERM;
    nl_d    = 1'b0;
    chr_d   = code_i;
    if (ascii_mode_i) begin
      if (code_i == ASCII_TERM) begin
        entry_o = UA_TERM;
      end else if (code_i >= ASCII_LO && code_i <= ASCII_HI) begin
        entry_o = UA_PASS;
      end else if (code_i == CH_CR || code_i == CH_LF) begin
        entry_o = UA_NL;
        nl_d    = 1'b1;
      end else begin
        entry_o = UA_HEX;
      end
    end else begin
      nl_d  = (low7 == LEGACY_NL);
      chr_d = low7[6] ? CH_QUEST : sym_lookup(low7[5:0]);
      if (code_i == LEGACY_TERM) begin
        entry_o = UA_TERM;
      end else if (code_i[7] && !inv_q) begin
        entry_o = UA_OPEN;
      end else if (!code_i[7] && inv_q) begin
        entry_o = UA_CLOSE;
      end else if (nl_d) begin
        entry_o = UA_NL;
      end else begin
        entry_o = UA_CHR;
      end
    end
  end

  always_comb begin
    case (ctrl_i.src)
      SRC_CHR:   emit_char = chr_q;
      SRC_LIT:   emit_char = ctrl_i.lit;
      SRC_HEXHI: emit_char = hex_digit(byte_q[7:4]);
      SRC_HEXLO: emit_char = hex_digit(byte_q[3:0]);
      default:   emit_char = ctrl_i.lit;
    endcase
  end

  always_comb begin
    inv_d = inv_q;
    if (ctrl_i.inv_set) begin
      inv_d = 1'b1;
    end else if (ctrl_i.inv_clr) begin
      inv_d = 1'b0;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = cnt_sat;
    end else if (ctrl_i.dec) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  assign out_free_o = !ovalid_q || out_ready_i;

  always_comb begin
    ovalid_d = ovalid_q;
    if (ctrl_i.emit) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      inv_q    <= inv_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    if (start_i) begin
      byte_q <= code_i;
      chr_q  <= chr_d;
      nl_q   <= nl_d;
      semi_q <= (cnt_sat > cnt_t'(6));
    end
    if (ctrl_i.emit) begin
      ochar_q <= emit_char;
      olast_q <= ctrl_i.last;
    end
  end

  always_comb begin
    stat_o.nl      = nl_q;
    stat_o.cnt_z   = (cnt_q == '0);
    stat_o.cnt_one = (cnt_q == cnt_t'(1));
    stat_o.semi    = semi_q;
  end

  assign out_valid_o = ovalid_q;
  assign out_char_o  = ochar_q;
  assign out_last_o  = olast_q;

endmodule

[design/legacy_charset_text_decoder.sv]
// Top level of the legacy charset text decoder: configuration registers and handshakes.
// Instantiates lctd_useq and lctd_dpath; depends on lctd_pkg.
//
// Usage: raw string bytes enter on the s_axis channel, one per transfer. Each
// byte yields zero or more characters on the m_axis channel; tlast marks the
// final character caused by that byte. Configuration is to be written through
// cfg_we_i / cfg_idx_i / cfg_data_i only while the block is idle, which the block
// does not enforce: index 0 is ascii_mode, index 1 is indent_width.
// Timing: after a byte is taken, a microprogram runs one step per cycle and
// each step places at most one character in the output register. A byte that
// causes n characters keeps the input side busy until its last step, and the
// next byte is taken only after the busy register has cleared. A hex escape is
// four characters; a newline with a bracket and full indent is 47 characters.
// A character appears on the output in the cycle after the step that makes it.
// When the receiver stalls, the sequencer holds its step until the output
// register is free; the input side stays closed until the byte is finished.
// Reset clears the sequencer, the output valid, the inverse-video flag and
// sets ascii_mode to 0 and indent_width to 6.
module legacy_charset_text_decoder import lctd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] code_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  cnt_t       cfg_data_i
);

  logic   ascii_mode_q;
  cnt_t   indent_q;
  logic   accept;
  logic   busy;
  uaddr_t entry;
  stat_t  stat;
  ctrl_t  ctrl;
  logic   out_free;

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ascii_mode_q <= 1'b0;
      indent_q     <= cnt_t'(6);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ASCII_MODE:   ascii_mode_q <= cfg_data_i[0];
        CFG_INDENT_WIDTH: indent_q     <= cfg_data_i;
        default:          ascii_mode_q <= ascii_mode_q;
      endcase
    end
  end

  lctd_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .entry_i    (entry),
    .stat_i     (stat),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .busy_o     (busy)
  );

  lctd_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (accept),
    .code_i       (s_axis_tdata),
    .ascii_mode_i (ascii_mode_q),
    .indent_i     (indent_q),
    .ctrl_i       (ctrl),
    .out_ready_i  (m_axis_tready),
    .entry_o      (entry),
    .stat_o       (stat),
    .out_free_o   (out_free),
    .out_valid_o  (m_axis_tvalid),
    .out_char_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

  // A taken byte always starts the sequencer.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("sequencer not started by an input transfer");

  // A terminator finishes in a single step and emits nothing.
  a_term_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && ((ascii_mode_q && s_axis_tdata == ASCII_TERM) ||
               (!ascii_mode_q && s_axis_tdata == LEGACY_TERM))
    |=> busy && !ctrl.emit ##1 !busy)
    else $error("terminator did not finish in one step");

  // A character is only written when the output register can take it.
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("character written over a held output");

endmodule

[sim/tb_legacy_charset_text_decoder.sv]
// Self-checking testbench for legacy_charset_text_decoder: a directed table, then random phases.
// Depends on lctd_pkg and the design files; expected characters come from a local decoder model or the directed table.
module tb_legacy_charset_text_decoder;
  import lctd_pkg::*;

  localparam int         RX_HOLDOFF  = 400;
  localparam int         SETTLE      = 64;
  localparam int         PHASES      = 8;
  localparam int         PHASE_BYTES = 40;
  localparam logic [7:0] CH_LF_OUT   = 8'h0A;

  // Legacy 64-symbol map, index 0 first.
  localparam logic [0:63][7:0] GLYPH = {8'h20, "abcdefghij", 8'h22, 8'hA3, "$:?",
                                        "()><=+-*/;,.", "0123456789",
                                        "ABCDEFGHIJKLMNOPQRSTUVWXYZ"};

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef enum logic [1:0] {ROW_BYTE, ROW_TYPED, ROW_CFG} row_e;

  typedef struct {
    row_e       kind;
    logic [7:0] val;
    logic       idx;
    int         n;
    logic [7:0] ch;
  } plan_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  cnt_t       cfg_data_i;

  // Decoder model state.
  logic       mdl_ascii;
  cnt_t       mdl_indent;
  logic       mdl_inverse;

  char_item_t char_q[$];
  char_item_t fresh_q[$];
  plan_row_t  plan_q[$];
  char_item_t seen_c;
  char_item_t want_c;
  int         n_err;
  bit         tx_gaps;
  bit         rx_gaps;
  bit         rx_holdoff_req;

  legacy_charset_text_decoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic void emit_char(input logic [7:0] c);
    char_item_t it;
    it.ch   = c;
    it.last = 1'b0;
    fresh_q.push_back(it);
  endfunction

  function automatic void emit_newline();
    int cnt;
    cnt = (int'(mdl_indent) > int'(MaxIndent)) ? int'(MaxIndent) : int'(mdl_indent);
    emit_char(CH_LF_OUT);
    for (int i = 0; i < cnt; i++) emit_char(CH_SPACE);
    if (cnt > 6) emit_char(CH_SEMI);
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] v);
    return (v < 4'd10) ? CH_ZERO + {4'h0, v} : CH_LOWA + {4'h0, v - 4'd10};
  endfunction

  // Fills fresh_q with the characters one code byte produces and updates the state.
  function automatic void decode_byte(input logic [7:0] b);
    logic [6:0] c;
    fresh_q.delete();
    c = b[6:0];
    if (mdl_ascii) begin
      if (b == ASCII_TERM) begin
        mdl_inverse = 1'b0;
      end else if (b >= ASCII_LO && b <= ASCII_HI) begin
        emit_char(b);
      end else if (b == CH_CR || b == CH_LF) begin
        emit_newline();
      end else begin
        emit_char(CH_LBRACE);
        emit_char(nibble_char(b[7:4]));
        emit_char(nibble_char(b[3:0]));
        emit_char(CH_RBRACE);
      end
    end else if (b == LEGACY_TERM) begin
      mdl_inverse = 1'b0;
    end else begin
      if (b[7] && !mdl_inverse) begin
        emit_char(CH_LBRACK);
        mdl_inverse = 1'b1;
      end else if (!b[7] && mdl_inverse) begin
        emit_char(CH_RBRACK);
        mdl_inverse = 1'b0;
      end
      if (c == LEGACY_NL) begin
        emit_newline();
      end else if (c > 7'h3F) begin
        emit_char(CH_QUEST);
      end else begin
        emit_char(GLYPH[c[5:0]]);
      end
    end
    if (fresh_q.size() > 0) fresh_q[fresh_q.size()-1].last = 1'b1;
  endfunction

  function automatic void plan_byte(input logic [7:0] v);
    plan_row_t r;
    r.kind = ROW_BYTE;
    r.val  = v;
    r.idx  = 1'b0;
    r.n    = 0;
    r.ch   = 8'h00;
    plan_q.push_back(r);
  endfunction

  function automatic void plan_typed(input logic [7:0] v, input int n, input logic [7:0] ch);
    plan_row_t r;
    r.kind = ROW_TYPED;
    r.val  = v;
    r.idx  = 1'b0;
    r.n    = n;
    r.ch   = ch;
    plan_q.push_back(r);
  endfunction

  function automatic void plan_cfg(input logic idx, input logic [7:0] v);
    plan_row_t r;
    r.kind = ROW_CFG;
    r.val  = v;
    r.idx  = idx;
    r.n    = 0;
    r.ch   = 8'h00;
    plan_q.push_back(r);
  endfunction

  // Offers one byte, waits for the transfer and queues what it should produce.
  // A typed row supplies its own expectation; the model still tracks state.
  task automatic send_byte(input logic [7:0] b, input bit typed, input int n,
                           input logic [7:0] ch);
    int         gap;
    char_item_t it;
    gap = 0;
    if (tx_gaps) begin
      while ($urandom_range(99) < 22) gap++;
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_byte(b);
    if (typed) begin
      if (n > 0) begin
        it.ch   = ch;
        it.last = 1'b1;
        char_q.push_back(it);
      end
    end else begin
      foreach (fresh_q[i]) char_q.push_back(fresh_q[i]);
    end
  endtask

  // Stops offering, waits for every expected character, then lets the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (char_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input cnt_t v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_ASCII_MODE) mdl_ascii = v[0];
    else mdl_indent = v;
  endtask

  // Output checker.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_c.ch   = m_axis_tdata;
      seen_c.last = m_axis_tlast;
      if (char_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) begin
          $display("unexpected character %02h last %0b with nothing pending",
                   seen_c.ch, seen_c.last);
        end
      end else begin
        want_c = char_q.pop_front();
        if (seen_c.ch !== want_c.ch || seen_c.last !== want_c.last) begin
          n_err++;
          if (n_err <= 10) begin
            $display("mismatch: char exp %02h got %02h, last exp %0b got %0b",
                     want_c.ch, seen_c.ch, want_c.last, seen_c.last);
          end
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin : rx_side
    int held;
    bit held_off;
    held_off      = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rx_holdoff_req && !held_off) begin
        m_axis_tready <= 1'b0;
        for (held = 0; held < RX_HOLDOFF; held++) @(posedge clk_i);
        held_off = 1'b1;
      end else begin
        m_axis_tready <= !(rx_gaps && $urandom_range(99) < 22);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("** legacy_charset_text_decoder: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] b;
    logic       inv_bit;
    int         r;
    cnt_t       ind;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = 8'h00;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_ASCII_MODE;
    cfg_data_i     = '0;
    tx_gaps        = 1'b1;
    rx_gaps        = 1'b1;
    inv_bit        = 1'b0;
    mdl_ascii      = 1'b0;
    mdl_indent     = cnt_t'(6);
    mdl_inverse    = 1'b0;

    // Legacy mode after reset, indent of six.
    plan_typed(8'h00, 1, CH_SPACE);     // a zero byte is a space here, not a terminator
    plan_typed(8'h0C, 1, 8'hA3);        // pound sign
    plan_typed(8'h3F, 1, 8'h5A);
    plan_typed(8'h40, 1, CH_QUEST);
    plan_byte(8'h76);
    plan_byte(8'h81);                   // inverse code one, not a terminator
    plan_typed(8'hFF, 1, CH_QUEST);     // inverse already open
    plan_byte(8'hF6);
    plan_byte(8'h00);                   // closes the inverse run first
    plan_byte(8'h80);
    plan_typed(LEGACY_TERM, 0, 8'h00);  // ends the inverse run silently
    plan_byte(8'h85);
    // Switching modes in the middle of a string keeps the inverse flag.
    plan_cfg(CFG_ASCII_MODE, 8'd1);
    plan_typed(8'h41, 1, 8'h41);
    plan_cfg(CFG_ASCII_MODE, 8'd0);
    plan_byte(8'h05);
    plan_cfg(CFG_ASCII_MODE, 8'd1);
    plan_typed(ASCII_TERM, 0, 8'h00);
    plan_typed(8'h20, 1, CH_SPACE);
    plan_typed(8'h7A, 1, 8'h7A);
    plan_byte(8'h7B);
    plan_byte(8'hFF);
    plan_cfg(CFG_INDENT_WIDTH, 8'd44);
    plan_byte(8'h0A);
    plan_cfg(CFG_INDENT_WIDTH, 8'd63);  // saturates at the maximum indent
    plan_byte(8'h0D);
    plan_cfg(CFG_INDENT_WIDTH, 8'd7);
    plan_byte(8'h0A);
    plan_cfg(CFG_INDENT_WIDTH, 8'd0);
    plan_byte(8'h0A);
    plan_cfg(CFG_ASCII_MODE, 8'd0);
    plan_byte(8'h76);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[i]) begin
      case (plan_q[i].kind)
        ROW_CFG: begin
          drain();
          cfg_write(plan_q[i].idx, cnt_t'(plan_q[i].val));
        end
        ROW_TYPED: send_byte(plan_q[i].val, 1'b1, plan_q[i].n, plan_q[i].ch);
        default:   send_byte(plan_q[i].val, 1'b0, 0, 8'h00);
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: ind = cnt_t'(3);
        1: ind = cnt_t'(44);
        2: ind = cnt_t'(63);
        3: ind = cnt_t'(0);
        default: ind = ($urandom_range(9) == 0) ? cnt_t'(63) : cnt_t'($urandom_range(10));
      endcase
      cfg_write(CFG_ASCII_MODE, (p < 4) ? cnt_t'(p % 2) : cnt_t'($urandom_range(1)));
      cfg_write(CFG_INDENT_WIDTH, ind);
      tx_gaps = (p != 5);
      rx_gaps = (p != 5);
      // Long receiver hold-off while the sender keeps offering bytes.
      if (p == 4) rx_holdoff_req = 1'b1;
      for (int k = 0; k < PHASE_BYTES; k++) begin
        r = $urandom_range(99);
        if (mdl_ascii) begin
          if (r < 60)      b = 8'($urandom_range(ASCII_HI, ASCII_LO));
          else if (r < 70) b = r[0] ? CH_CR : CH_LF;
          else if (r < 75) b = ASCII_TERM;
          else             b = 8'($urandom_range(255));
        end else begin
          // Inverse video comes in runs, as in stored strings.
          if ($urandom_range(99) < 20) inv_bit = ~inv_bit;
          if (r < 50)      b = {inv_bit, 1'b0, 6'($urandom_range(63))};
          else if (r < 60) b = {inv_bit, LEGACY_NL};
          else if (r < 65) b = LEGACY_TERM;
          else if (r < 70) b = {1'b1, LEGACY_TERM[6:0]};
          else             b = 8'($urandom_range(255));
        end
        send_byte(b, 1'b0, 0, 8'h00);
      end
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;

    drain();
    if (n_err == 0 && char_q.size() == 0) begin
      $display("** legacy_charset_text_decoder: PASSED **");
    end else begin
      $display("** legacy_charset_text_decoder: FAILED **");
    end
    $finish;
  end

endmodule
